[rtl/mste_pkg.sv]
// ----------------------------------------------------------------------------
// mste_pkg
// Shared types and constants of the MP4 sample table expander.
// ----------------------------------------------------------------------------
`default_nettype none

package mste_pkg;

  typedef enum logic [1:0] {
    OP_RUN    = 2'd0,
    OP_CHUNK  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NO_SAMPLE = 2'd2,
    STS_ALL_DONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_UNIFORM = 2'd0,
    REG_TOTAL   = 2'd1,
    REG_FILE    = 2'd2
  } cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  localparam logic [23:0] MaxTotal  = 24'd10000000;
  localparam logic [31:0] NoNextRun = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

[rtl/mste_ram.sv]
// ----------------------------------------------------------------------------
// mste_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mste_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/mp4_sample_table_expander.sv]
// Run-load, sample and status items give their result in the cycle after start.
// A chunk item gives its result at the end of its scan: the run
// table memory is scanned one entry per cycle through its single read port.
// Throughput: one item at a time; busy_o is high during the scan, a new item may
// start in the cycle its predecessor's result strobe is high. The receiver cannot stall.
// Reset clears all control state and counters; the run table needs no clearing.
// ----------------------------------------------------------------------------
// mp4_sample_table_expander
// Expands sample-to-chunk runs, chunk offsets and sample sizes into per-sample
// frame offsets and sizes, with a file-end bound check.
// ----------------------------------------------------------------------------
`default_nettype none

module mp4_sample_table_expander #(
  parameter int RUN_TABLE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] run_first_chunk_i,
  input  wire logic [31:0] run_samples_i,
  input  wire logic [63:0] chunk_offset_i,
  input  wire logic [31:0] sample_size_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [31:0]      frame_offset_o,
  output logic [31:0]      frame_size_o,
  output logic [31:0]      chunk_samples_o,
  output logic             size_clamped_o,
  output logic             last_frame_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  import mste_pkg::*;

  localparam int AW = (RUN_TABLE_DEPTH > 1) ? $clog2(RUN_TABLE_DEPTH) : 1;
  localparam int CW = $clog2(RUN_TABLE_DEPTH + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] runs_q, runs_d;
  logic [31:0]   chunk_q, chunk_d;
  logic [63:0]   offset_q, offset_d;
  logic [31:0]   left_q, left_d;
  logic [23:0]   emitted_q, emitted_d;

  logic [31:0]   uniform_q;
  logic [23:0]   total_q;
  logic [31:0]   file_q;

  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic          ram_vld_q, ram_vld_d;
  logic          prev_vld_q, prev_vld_d;
  logic [31:0]   prev_first_q, prev_first_d;
  logic [31:0]   prev_count_q, prev_count_d;

  logic          done_q, done_d;
  status_e       status_q, status_d;
  logic [31:0]   foff_q, foff_d;
  logic [31:0]   fsize_q, fsize_d;
  logic [31:0]   csamp_q, csamp_d;
  logic          clamp_q, clamp_d;
  logic          last_q, last_d;

  logic          ram_we;
  logic [63:0]   ram_rdata;

  logic          accept;
  logic [23:0]   total_eff;
  logic [23:0]   remain;
  logic          all_done;
  logic [31:0]   sz;
  logic [64:0]   sum;
  logic          over;
  logic [31:0]   cur_first;
  logic [31:0]   cur_count;
  logic          hit_prev;
  logic          hit_last;
  logic          scan_hit;
  logic          scan_end;
  logic          scan_final;
  logic [31:0]   spc;
  logic [31:0]   spc_clip;

  mste_ram #(
    .WIDTH (64),
    .DEPTH (RUN_TABLE_DEPTH)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (runs_q[AW-1:0]),
    .wdata_i ({run_first_chunk_i, run_samples_i}),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign accept    = start_i && (state_q == ST_IDLE);
  assign total_eff = (total_q > MaxTotal) ? MaxTotal : total_q;
  assign remain    = total_eff - emitted_q;
  assign all_done  = emitted_q >= total_eff;
  assign sz        = (uniform_q != 32'd0) ? uniform_q : sample_size_i;
  assign sum       = {1'b0, offset_q} + {33'd0, sz};
  assign over      = sum > {33'd0, file_q};

  assign cur_first  = ram_rdata[63:32];
  assign cur_count  = ram_rdata[31:0];
  assign hit_prev   = prev_vld_q && (chunk_q >= prev_first_q) && (chunk_q < cur_first);
  assign hit_last   = prev_vld_q && (chunk_q >= prev_first_q) && (chunk_q != NoNextRun);
  assign scan_hit   = ram_vld_q && hit_prev;
  assign scan_end   = !ram_vld_q && (rd_idx_q == runs_q);
  assign scan_final = scan_hit || scan_end;
  assign spc        = (scan_hit || hit_last) ? prev_count_q : 32'd1;
  assign spc_clip   = (spc > {8'd0, remain}) ? {8'd0, remain} : spc;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (op_e'(opcode_i) == OP_CHUNK) && !all_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_final) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    runs_d       = runs_q;
    chunk_d      = chunk_q;
    offset_d     = offset_q;
    left_d       = left_q;
    emitted_d    = emitted_q;
    rd_idx_d     = rd_idx_q;
    ram_vld_d    = 1'b0;
    prev_vld_d   = prev_vld_q;
    prev_first_d = prev_first_q;
    prev_count_d = prev_count_q;
    ram_we       = 1'b0;
    done_d       = 1'b0;
    status_d     = STS_OK;
    foff_d       = 32'd0;
    fsize_d      = 32'd0;
    csamp_d      = 32'd0;
    clamp_d      = 1'b0;
    last_d       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (op_e'(opcode_i))
            OP_RUN: begin
              if (runs_q == CW'(RUN_TABLE_DEPTH)) begin
                status_d = STS_FULL;
              end else begin
                ram_we = 1'b1;
                runs_d = runs_q + CW'(1);
              end
            end
            OP_CHUNK: begin
              if (all_done) begin
                status_d = STS_ALL_DONE;
              end else begin
                done_d     = 1'b0;
                chunk_d    = chunk_q + 32'd1;
                offset_d   = chunk_offset_i;
                rd_idx_d   = '0;
                prev_vld_d = 1'b0;
              end
            end
            OP_SAMPLE: begin
              if (all_done) begin
                status_d = STS_ALL_DONE;
              end else if (left_q == 32'd0) begin
                status_d = STS_NO_SAMPLE;
              end else begin
                foff_d    = offset_q[31:0];
                fsize_d   = over ? 32'd0 : sz;
                clamp_d   = over;
                offset_d  = over ? offset_q : sum[63:0];
                emitted_d = emitted_q + 24'd1;
                left_d    = left_q - 32'd1;
                last_d    = (emitted_q + 24'd1) == total_eff;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ram_vld_q && !hit_prev) begin
          prev_vld_d   = 1'b1;
          prev_first_d = cur_first;
          prev_count_d = cur_count;
        end
        if (rd_idx_q < runs_q) begin
          ram_vld_d = 1'b1;
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        if (scan_final) begin
          done_d  = 1'b1;
          csamp_d = spc_clip;
          left_d  = spc_clip;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      runs_q     <= '0;
      chunk_q    <= 32'd0;
      offset_q   <= 64'd0;
      left_q     <= 32'd0;
      emitted_q  <= 24'd0;
      uniform_q  <= 32'd0;
      total_q    <= 24'd1;
      file_q     <= 32'd0;
      rd_idx_q   <= '0;
      ram_vld_q  <= 1'b0;
      prev_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      runs_q     <= runs_d;
      chunk_q    <= chunk_d;
      offset_q   <= offset_d;
      left_q     <= left_d;
      emitted_q  <= emitted_d;
      rd_idx_q   <= rd_idx_d;
      ram_vld_q  <= ram_vld_d;
      prev_vld_q <= prev_vld_d;
      done_q     <= done_d;
      if (cfg_valid_i) begin
        case (cfg_e'(cfg_index_i))
          REG_UNIFORM: uniform_q <= cfg_data_i;
          REG_TOTAL:   total_q   <= cfg_data_i[23:0];
          REG_FILE:    file_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_first_q <= prev_first_d;
    prev_count_q <= prev_count_d;
    status_q     <= status_d;
    foff_q       <= foff_d;
    fsize_q      <= fsize_d;
    csamp_q      <= csamp_d;
    clamp_q      <= clamp_d;
    last_q       <= last_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign frame_offset_o  = foff_q;
  assign frame_size_o    = fsize_q;
  assign chunk_samples_o = csamp_q;
  assign size_clamped_o  = clamp_q;
  assign last_frame_o    = last_q;

  a_done_has_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i && !busy_o) || $past(state_q == ST_SCAN)))
    else $error("result strobe without an item at work");

  a_runs_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    runs_q <= CW'(RUN_TABLE_DEPTH))
    else $error("run count passed table depth");

  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("run table written during scan");

  a_chunk_enters_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_CHUNK) && !all_done) |=> (busy_o && !done_o))
    else $error("chunk item did not start a scan");

  a_emitted_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= MaxTotal)
    else $error("sample count passed the largest total");

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the MP4 sample table expander item by item. A queue of table commands
// feeds a driver; each accepted command runs through a local model of the run
// table, chunk and sample counters, and the frame locations that the block
// reports are compared field by field against the model, in order.
// ----------------------------------------------------------------------------
module tb;
  import mste_pkg::*;

  localparam logic [1:0] OpIgnored = 2'd3;
  localparam int RunDepth = 64;
  localparam int DrainCycles = 80;

  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] run_first;
    logic [31:0] run_count;
    logic [63:0] chunk_off;
    logic [31:0] smp_size;
  } stbl_cmd_t;

  typedef struct {
    status_e     status;
    logic [31:0] frame_off;
    logic [31:0] frame_len;
    logic [31:0] chunk_cnt;
    logic        clamped;
    logic        last;
  } frame_loc_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  opcode_i = '0;
  logic [31:0] run_first_chunk_i = '0;
  logic [31:0] run_samples_i = '0;
  logic [63:0] chunk_offset_i = '0;
  logic [31:0] sample_size_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] frame_offset_o;
  logic [31:0] frame_size_o;
  logic [31:0] chunk_samples_o;
  logic        size_clamped_o;
  logic        last_frame_o;
  logic        cfg_ready_o;

  mp4_sample_table_expander #(.RUN_TABLE_DEPTH(RunDepth)) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .opcode_i          (opcode_i),
    .run_first_chunk_i (run_first_chunk_i),
    .run_samples_i     (run_samples_i),
    .chunk_offset_i    (chunk_offset_i),
    .sample_size_i     (sample_size_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .frame_offset_o    (frame_offset_o),
    .frame_size_o      (frame_size_o),
    .chunk_samples_o   (chunk_samples_o),
    .size_clamped_o    (size_clamped_o),
    .last_frame_o      (last_frame_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // model state
  logic [31:0] run_first_mem [RunDepth];
  logic [31:0] run_count_mem [RunDepth];
  int unsigned runs_held = 0;
  logic [31:0] chunk_num = '0;
  logic [63:0] byte_pos = '0;
  logic [31:0] chunk_left = '0;
  logic [23:0] emitted_cnt = '0;
  logic [31:0] uniform_reg = '0;
  logic [23:0] total_reg = 24'd1;
  logic [31:0] file_reg = '0;

  stbl_cmd_t  cmd_q[$];
  frame_loc_t loc_q[$];
  int         mismatches = 0;
  int         gap_pct = 9;
  int         loads_made = 0;
  logic [31:0] chunks_made = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic frame_loc_t expand_cmd(stbl_cmd_t c);
    frame_loc_t r;
    logic [31:0] lim, remain, spc, nxt, sz;
    bit found;
    r.status = STS_OK;
    r.frame_off = '0;
    r.frame_len = '0;
    r.chunk_cnt = '0;
    r.clamped = 1'b0;
    r.last = 1'b0;
    lim = (total_reg > MaxTotal) ? {8'd0, MaxTotal} : {8'd0, total_reg};
    case (c.opcode)
      OP_RUN: begin
        if (runs_held < RunDepth) begin
          run_first_mem[runs_held] = c.run_first;
          run_count_mem[runs_held] = c.run_count;
          runs_held++;
        end else begin
          r.status = STS_FULL;
        end
      end
      OP_CHUNK: begin
        if ({8'd0, emitted_cnt} >= lim) begin
          r.status = STS_ALL_DONE;
        end else begin
          remain = lim - {8'd0, emitted_cnt};
          chunk_num = chunk_num + 32'd1;
          spc = 32'd1;
          found = 1'b0;
          for (int e = 0; e < runs_held && !found; e++) begin
            nxt = (e + 1 < runs_held) ? run_first_mem[e + 1] : NoNextRun;
            if (chunk_num >= run_first_mem[e] && chunk_num < nxt) begin
              spc = run_count_mem[e];
              found = 1'b1;
            end
          end
          if (spc > remain) spc = remain;
          chunk_left = spc;
          byte_pos = c.chunk_off;
          r.chunk_cnt = spc;
        end
      end
      OP_SAMPLE: begin
        if ({8'd0, emitted_cnt} >= lim) begin
          r.status = STS_ALL_DONE;
        end else if (chunk_left == 0) begin
          r.status = STS_NO_SAMPLE;
        end else begin
          sz = (uniform_reg != 0) ? uniform_reg : c.smp_size;
          if ({32'd0, sz} > {32'd0, file_reg} ||
              byte_pos > {32'd0, file_reg} - {32'd0, sz}) begin
            sz = '0;
            r.clamped = 1'b1;
          end
          r.frame_off = byte_pos[31:0];
          r.frame_len = sz;
          byte_pos = byte_pos + {32'd0, sz};
          emitted_cnt = emitted_cnt + 24'd1;
          chunk_left = chunk_left - 32'd1;
          r.last = ({8'd0, emitted_cnt} == lim);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (cmd_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
      start_i <= 1'b1;
      opcode_i <= cmd_q[0].opcode;
      run_first_chunk_i <= cmd_q[0].run_first;
      run_samples_i <= cmd_q[0].run_count;
      chunk_offset_i <= cmd_q[0].chunk_off;
      sample_size_i <= cmd_q[0].smp_size;
    end else begin
      start_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      loc_q.push_back(expand_cmd('{opcode_i, run_first_chunk_i, run_samples_i,
                                   chunk_offset_i, sample_size_i}));
      void'(cmd_q.pop_front());
    end
  end

  always @(posedge clk_i) begin : check_frames
    frame_loc_t want;
    if (rst_ni && done_o) begin
      if (loc_q.size() == 0) begin
        $error("result strobe with no item outstanding");
        mismatches++;
      end else begin
        want = loc_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (frame_offset_o !== want.frame_off) begin
          $error("frame_offset: expected %0h, got %0h", want.frame_off, frame_offset_o);
          mismatches++;
        end
        if (frame_size_o !== want.frame_len) begin
          $error("frame_size: expected %0h, got %0h", want.frame_len, frame_size_o);
          mismatches++;
        end
        if (chunk_samples_o !== want.chunk_cnt) begin
          $error("chunk_samples: expected %0d, got %0d", want.chunk_cnt, chunk_samples_o);
          mismatches++;
        end
        if (size_clamped_o !== want.clamped) begin
          $error("size_clamped: expected %0b, got %0b", want.clamped, size_clamped_o);
          mismatches++;
        end
        if (last_frame_o !== want.last) begin
          $error("last_frame: expected %0b, got %0b", want.last, last_frame_o);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(cfg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_UNIFORM: uniform_reg = val;
      REG_TOTAL:   total_reg = val[23:0];
      REG_FILE:    file_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || loc_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_cmd(logic [1:0] op, logic [31:0] first, logic [31:0] count,
                           logic [63:0] off, logic [31:0] sz);
    cmd_q.push_back('{op, first, count, off, sz});
  endtask

  task automatic queue_random(int n);
    int made, r, s;
    logic [1:0]  op;
    logic [63:0] off;
    logic [31:0] sz;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        if (loads_made == 62)
          queue_cmd(OP_RUN, NoNextRun, $urandom_range(1, 4), {$urandom, $urandom}, $urandom);
        else if (r == 0)
          queue_cmd(OP_RUN, $urandom, $urandom, {$urandom, $urandom}, $urandom);
        else
          queue_cmd(OP_RUN, chunks_made + $urandom_range(1, 8),
                    ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 5),
                    {$urandom, $urandom}, $urandom);
        loads_made++;
        made++;
      end else if (r < 9) begin
        op = (r == 8) ? OP_SAMPLE : OpIgnored;
        queue_cmd(op, $urandom, $urandom, {$urandom, $urandom}, $urandom);
        made++;
      end else begin
        s = $urandom_range(0, 9);
        if (s == 0) off = '0;
        else if (s == 1) off = {$urandom, $urandom};
        else off = {32'd0, $urandom_range(0, file_reg)};
        queue_cmd(OP_CHUNK, $urandom, $urandom, off, $urandom);
        chunks_made++;
        made++;
        repeat ($urandom_range(0, 5)) begin
          s = $urandom_range(0, 19);
          if (s == 0) sz = $urandom;
          else if (s == 1) sz = '0;
          else if (s == 2) sz = 32'hFFFF_FFFF;
          else sz = $urandom_range(0, 2048);
          queue_cmd(OP_SAMPLE, $urandom, $urandom, {$urandom, $urandom}, sz);
          made++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(REG_UNIFORM, 32'd0);
    write_reg(REG_TOTAL, 32'd10);
    write_reg(REG_FILE, 32'd1000);

    // no chunk open, ignored opcode, chunk with an empty run table
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd5);
    queue_cmd(OpIgnored, '1, '1, '1, '1);
    queue_cmd(OP_CHUNK, '0, '0, 64'd100, '0);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd50);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd50);
    queue_cmd(OP_RUN, 32'd0, 32'd2, '0, '0);
    queue_cmd(OP_RUN, 32'd3, 32'd0, '0, '0);
    queue_cmd(OP_RUN, 32'd5, 32'hFFFF_FFFF, '0, '0);
    queue_cmd(OP_RUN, 32'd7, 32'd3, '0, '0);
    // exact fit at file end, then one byte past it
    queue_cmd(OP_CHUNK, '0, '0, 64'd990, '0);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd10);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd1);
    // runs of zero samples per chunk
    queue_cmd(OP_CHUNK, '0, '0, 64'd0, '0);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd1);
    queue_cmd(OP_CHUNK, '0, '0, '1, '0);
    // huge run clipped to what remains, offset above 32 bits
    queue_cmd(OP_CHUNK, '0, '0, 64'hFFFF_FFFF_0000_0010, '0);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'hFFFF_FFFF);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd0);
    // drop the rest of the open chunk
    queue_cmd(OP_CHUNK, '0, '0, 64'd200, '0);
    repeat (5) queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd100);
    queue_cmd(OP_SAMPLE, '0, '0, '0, 32'd100);
    queue_cmd(OP_CHUNK, '0, '0, 64'd300, '0);
    loads_made = 4;
    chunks_made = 32'd6;
    drain();

    for (int p = 0; p < 9; p++) begin
      gap_pct = (p == 4) ? 0 : 9;
      case (p)
        0: begin
          write_reg(REG_UNIFORM, 32'd0);
          write_reg(REG_FILE, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_UNIFORM, 32'hFFFF_FFFF);
          write_reg(REG_FILE, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(REG_UNIFORM, $urandom_range(1, 512));
          write_reg(REG_FILE, $urandom);
        end
        3: begin
          write_reg(REG_UNIFORM, 32'd0);
          write_reg(REG_FILE, 32'd0);
        end
        4: begin
          write_reg(REG_UNIFORM, 32'd0);
          write_reg(REG_FILE, 32'hFFFF_FFFF);
        end
        5: begin
          write_reg(REG_UNIFORM, 32'd0);
          write_reg(REG_FILE, $urandom_range(0, 20000));
        end
        6: begin
          write_reg(REG_UNIFORM, $urandom_range(1, 64));
          write_reg(REG_FILE, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_UNIFORM, ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom_range(1, 300));
          write_reg(REG_FILE, $urandom);
        end
      endcase
      if (p == 3) write_reg(REG_TOTAL, 32'd0);
      else if (p == 4) write_reg(REG_TOTAL, 32'h00FF_FFFF);
      else write_reg(REG_TOTAL, {8'd0, emitted_cnt} + $urandom_range(40, 100));
      queue_random((p == 3) ? 30 : 150);
      drain();
    end

    if (mismatches == 0 && loc_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
